// ===== rtl/multi_slot_alarm_timer_assert.svh =====
// Assertion macros for the alarm timer
`ifndef MULTI_SLOT_ALARM_TIMER_ASSERT_SVH
`define MULTI_SLOT_ALARM_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
`define MSAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSAT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MSAT_ASSERT(lbl, prop, msg)
`define MSAT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/msat_pkg.sv =====
package msat_pkg;

    localparam int SLOTS   = 5;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 15;
    localparam int TOTAL_W = 5;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CREATE = 2'd1;
    localparam logic [1:0] KIND_SET    = 2'd2;

    localparam logic [1:0] RES_FIRED  = 2'd0;
    localparam logic [1:0] RES_CREATE = 2'd1;
    localparam logic [1:0] RES_DONE   = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic               one_shot;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [SLOT_W-1:0]  result_slot;
        logic               accepted;
        logic [TOTAL_W-1:0] active_slots;
        logic               timer_running;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic               live;
        logic               hit;
        logic [SLOT_W-1:0]  where;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic               one_shot;
    } tok_t;

    typedef struct packed {
        logic fire;
        logic freed;
        logic taken;
    } evt_t;

endpackage

// ===== rtl/msat_cell.sv =====
module msat_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [msat_pkg::SLOT_W-1:0] idx,
    input  logic                        go,
    input  msat_pkg::tok_t              tok_in,
    output msat_pkg::tok_t              tok_out,
    output msat_pkg::evt_t              evt
);
    import msat_pkg::*;

    logic               active_reg,  active_next;
    logic [COUNT_W-1:0] rem_reg,     rem_next;
    logic [COUNT_W-1:0] period_reg,  period_next;
    logic               repeats_reg, repeats_next;
    tok_t               tok_reg,     tok_next;
    logic [COUNT_W-1:0] rem_dec;

    always_comb
    begin
        active_next  = active_reg;
        rem_next     = rem_reg;
        period_next  = period_reg;
        repeats_next = repeats_reg;
        tok_next     = tok_in;
        evt          = '0;
        rem_dec      = (rem_reg != '0) ? rem_reg - COUNT_W'(1) : rem_reg;
        if (go && tok_in.valid)
        begin
            case (tok_in.kind)
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            evt.fire = 1'b1;
                            if (repeats_reg)
                            begin
                                rem_next = period_reg;
                            end
                            else
                            begin
                                active_next = 1'b0;
                                rem_next    = '0;
                                period_next = '0;
                                evt.freed   = 1'b1;
                            end
                        end
                    end
                end
                KIND_CREATE:
                begin
                    if (tok_in.live && !active_reg)
                    begin
                        active_next    = 1'b1;
                        rem_next       = tok_in.count;
                        repeats_next   = !tok_in.one_shot;
                        period_next    = tok_in.one_shot ? '0 : tok_in.count;
                        tok_next.live  = 1'b0;
                        tok_next.hit   = 1'b1;
                        tok_next.where = idx;
                        evt.taken      = 1'b1;
                    end
                end
                KIND_SET:
                begin
                    if (tok_in.slot == idx && active_reg)
                    begin
                        tok_next.hit = 1'b1;
                        if (tok_in.count != '0)
                        begin
                            rem_next = tok_in.count;
                        end
                        else
                        begin
                            active_next  = 1'b0;
                            rem_next     = '0;
                            period_next  = '0;
                            repeats_next = 1'b0;
                            evt.freed    = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            rem_reg     <= '0;
            period_reg  <= '0;
            repeats_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            rem_reg     <= rem_next;
            period_reg  <= period_next;
            repeats_reg <= repeats_next;
            if (go)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/multi_slot_alarm_timer.sv =====
// Multi-slot alarm timer.
// Input channel (in_valid/in_stall/in_data) takes one transaction per command:
// tick, create alarm, or set count / cancel. Output channel
// (out_valid/out_stall/out_data) returns the results: one fired result per
// slot that expires on a tick, then one status result with last set.
// The command walks a row of slot cells, one cell per cycle while no pending
// result is held by out_stall; it passes the entry register, each cell's
// token register and the output register. in_stall stays high until the
// status result is loaded, so no new transaction is taken during a walk.
// While out_stall holds a pending result, the walk pauses in place until the
// result is taken; only a new transaction can still enter the entry register.
// Reset clears every slot to inactive, the active count to zero and the
// tick-wanted flag to zero; the block can take a transaction as soon as
// reset is released.
`include "multi_slot_alarm_timer_assert.svh"

module multi_slot_alarm_timer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msat_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output msat_pkg::out_item_t out_data
);
    import msat_pkg::*;

    tok_t               tok [SLOTS+1];
    evt_t               evt [SLOTS];
    logic [SLOTS-1:0]   fire_vec;
    logic               go;
    logic               accept;
    logic               any_fire;
    logic               any_freed;
    logic               any_taken;
    logic [SLOT_W-1:0]  fire_slot;
    tok_t               tail;

    logic               busy_reg,      busy_next;
    logic [TOTAL_W-1:0] total_reg,     total_next;
    logic               running_reg,   running_next;
    tok_t               entry_reg,     entry_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg,       out_next;

    assign go     = !out_valid_reg || !out_stall;
    assign accept = in_valid && !busy_reg;
    assign tok[0] = entry_reg;
    assign tail   = tok[SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        msat_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (SLOT_W'(i)),
            .go      (go),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .evt     (evt[i])
        );
        assign fire_vec[i] = evt[i].fire;
    end

    always_comb
    begin
        any_fire  = 1'b0;
        any_freed = 1'b0;
        any_taken = 1'b0;
        fire_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            any_fire  = any_fire  | evt[i].fire;
            any_freed = any_freed | evt[i].freed;
            any_taken = any_taken | evt[i].taken;
            if (evt[i].fire)
            begin
                fire_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        total_next     = total_reg + TOTAL_W'(any_taken) - TOTAL_W'(any_freed);
        running_next   = running_reg;
        entry_next     = entry_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (go)
        begin
            entry_next.valid = 1'b0;
            if (any_fire)
            begin
                out_valid_next         = 1'b1;
                out_next.result_kind   = RES_FIRED;
                out_next.result_slot   = fire_slot;
                out_next.accepted      = 1'b0;
                out_next.active_slots  = total_reg - TOTAL_W'(any_freed);
                out_next.timer_running = running_reg;
                out_next.last          = 1'b0;
            end
            else if (tail.valid)
            begin
                out_valid_next         = 1'b1;
                out_next.result_kind   = (tail.kind == KIND_CREATE) ? RES_CREATE : RES_DONE;
                out_next.result_slot   = (tail.kind == KIND_CREATE) ? tail.where : '0;
                out_next.accepted      = tail.hit;
                out_next.active_slots  = total_reg;
                out_next.timer_running = (total_reg != '0);
                out_next.last          = 1'b1;
                running_next           = (total_reg != '0);
                busy_next              = 1'b0;
            end
        end

        if (accept)
        begin
            busy_next           = 1'b1;
            entry_next.valid    = 1'b1;
            entry_next.kind     = in_data.kind;
            entry_next.slot     = in_data.slot;
            entry_next.count    = in_data.count;
            entry_next.one_shot = in_data.one_shot;
            entry_next.hit      = 1'b0;
            entry_next.where    = '0;
            entry_next.live     = (in_data.kind == KIND_CREATE)
                                  && (total_reg < TOTAL_W'(SLOTS))
                                  && (in_data.count != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            total_reg     <= '0;
            running_reg   <= 1'b0;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            total_reg     <= total_next;
            running_reg   <= running_next;
            entry_reg     <= entry_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `MSAT_ASSERT(a_total_range, total_reg <= TOTAL_W'(SLOTS), "active count above slot count")
    `MSAT_ASSERT(a_one_fire, $onehot0(fire_vec), "more than one slot fired in a cycle")
    `MSAT_ASSERT(a_idle_running, !busy_reg |-> (running_reg == (total_reg != '0)),
                 "tick flag out of step with active count")
    `MSAT_ASSERT_NEXT(a_accept_busy, accept, busy_reg && entry_reg.valid,
                      "accepted command did not enter the chain")

endmodule

// ===== sim/tb_multi_slot_alarm_timer.sv =====
module tb_multi_slot_alarm_timer;
    import msat_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 236;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        in_item_t  cmd;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    logic               live [SLOTS];
    logic [COUNT_W-1:0] remain [SLOTS];
    logic [COUNT_W-1:0] period [SLOTS];
    logic               periodic [SLOTS];
    logic [TOTAL_W-1:0] n_active;
    logic               running;

    out_item_t alarm_reports [$];
    plan_row_t plan [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;

    multi_slot_alarm_timer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_alarms();
        for (int i = 0; i < SLOTS; i++)
        begin
            live[i]     = 1'b0;
            remain[i]   = '0;
            period[i]   = '0;
            periodic[i] = 1'b0;
        end
        n_active = '0;
        running  = 1'b0;
    endfunction

    function automatic void push_report(logic [1:0] rk, int rslot, logic acc, logic fin);
        out_item_t r;
        r.result_kind   = rk;
        r.result_slot   = rslot[SLOT_W-1:0];
        r.accepted      = acc;
        r.active_slots  = n_active;
        r.timer_running = running;
        r.last          = fin;
        alarm_reports.push_back(r);
    endfunction

    function automatic void apply_command(in_item_t cmd);
        logic got;
        int   where;
        got   = 1'b0;
        where = 0;
        case (cmd.kind)
            KIND_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (live[i])
                    begin
                        if (remain[i] != 0)
                            remain[i] = remain[i] - COUNT_W'(1);
                        if (remain[i] == 0)
                        begin
                            if (periodic[i])
                                remain[i] = period[i];
                            else
                            begin
                                live[i]   = 1'b0;
                                remain[i] = '0;
                                period[i] = '0;
                                if (n_active != 0)
                                    n_active = n_active - TOTAL_W'(1);
                            end
                            push_report(RES_FIRED, i, 1'b0, 1'b0);
                        end
                    end
                end
                running = (n_active != 0);
                push_report(RES_DONE, 0, 1'b0, 1'b1);
            end
            KIND_CREATE:
            begin
                if (n_active < SLOTS && cmd.count != 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!live[i] && !got)
                        begin
                            live[i]     = 1'b1;
                            remain[i]   = cmd.count;
                            periodic[i] = !cmd.one_shot;
                            period[i]   = cmd.one_shot ? '0 : cmd.count;
                            n_active    = n_active + TOTAL_W'(1);
                            got         = 1'b1;
                            where       = i;
                        end
                    end
                    running = (n_active != 0);
                end
                push_report(RES_CREATE, where, got, 1'b1);
            end
            KIND_SET:
            begin
                if (cmd.slot < SLOTS && live[cmd.slot])
                begin
                    if (cmd.count != 0)
                        remain[cmd.slot] = cmd.count;
                    else
                    begin
                        live[cmd.slot]     = 1'b0;
                        remain[cmd.slot]   = '0;
                        period[cmd.slot]   = '0;
                        periodic[cmd.slot] = 1'b0;
                        if (n_active != 0)
                            n_active = n_active - TOTAL_W'(1);
                    end
                    got     = 1'b1;
                    running = (n_active != 0);
                end
                push_report(RES_DONE, 0, got, 1'b1);
            end
            default:
                push_report(RES_DONE, 0, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic plan_row_t row(logic [1:0] kind, int slot, int count, logic os,
                                      bit typed, logic [1:0] rk, int rslot, logic acc,
                                      int act, logic run);
        plan_row_t p;
        p.cmd.kind               = kind;
        p.cmd.slot               = slot[SLOT_W-1:0];
        p.cmd.count              = count[COUNT_W-1:0];
        p.cmd.one_shot           = os;
        p.typed                  = typed;
        p.want.result_kind       = rk;
        p.want.result_slot       = rslot[SLOT_W-1:0];
        p.want.accepted          = acc;
        p.want.active_slots      = act[TOTAL_W-1:0];
        p.want.timer_running     = run;
        p.want.last              = 1'b1;
        return p;
    endfunction

    function automatic in_item_t random_cmd();
        in_item_t cmd;
        int       sel;
        sel          = $urandom_range(0, 99);
        cmd.slot     = SLOT_W'($urandom_range(0, 15));
        cmd.count    = COUNT_W'($urandom_range(0, 32767));
        cmd.one_shot = 1'($urandom_range(0, 1));
        if (sel < 40)
            cmd.kind = KIND_TICK;
        else if (sel < 70)
        begin
            cmd.kind = KIND_CREATE;
            if ($urandom_range(0, 9) != 0)
                cmd.count = COUNT_W'($urandom_range(0, 6));
        end
        else if (sel < 96)
        begin
            cmd.kind = KIND_SET;
            if ($urandom_range(0, 7) != 0)
                cmd.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 3) == 0)
                cmd.count = '0;
            else if ($urandom_range(0, 9) != 0)
                cmd.count = COUNT_W'($urandom_range(1, 6));
        end
        else
            cmd.kind = KIND_UNUSED;
        return cmd;
    endfunction

    task automatic send_cmd(in_item_t cmd, bit typed, out_item_t want);
        in_data  <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_command(cmd);
        if (typed)
        begin
            void'(alarm_reports.pop_back());
            alarm_reports.push_back(want);
        end
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (alarm_reports.size() == 0)
            begin
                $error("result_kind: expected none, got %0d", out_data.result_kind);
                mismatches++;
            end
            else
            begin
                want = alarm_reports.pop_front();
                check_field("result_kind", int'(want.result_kind),
                            int'(out_data.result_kind));
                check_field("result_slot", int'(want.result_slot),
                            int'(out_data.result_slot));
                check_field("accepted", int'(want.accepted), int'(out_data.accepted));
                check_field("active_slots", int'(want.active_slots),
                            int'(out_data.active_slots));
                check_field("timer_running", int'(want.timer_running),
                            int'(out_data.timer_running));
                check_field("last", int'(want.last), int'(out_data.last));
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(1, 6);
            out_stall <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        out_item_t none;
        none = '0;
        clear_alarms();

        plan.push_back(row(KIND_TICK,    0,     0, 0, 1, RES_DONE,   0, 0, 0, 0));
        plan.push_back(row(KIND_SET,     0,     5, 0, 1, RES_DONE,   0, 0, 0, 0));
        plan.push_back(row(KIND_CREATE,  0,     0, 1, 1, RES_CREATE, 0, 0, 0, 0));
        plan.push_back(row(KIND_UNUSED, 15, 32767, 1, 1, RES_DONE,   0, 0, 0, 0));
        plan.push_back(row(KIND_CREATE,  0,     1, 1, 1, RES_CREATE, 0, 1, 1, 1));
        plan.push_back(row(KIND_CREATE,  0, 32767, 0, 1, RES_CREATE, 1, 1, 2, 1));
        plan.push_back(row(KIND_CREATE,  0,     2, 0, 1, RES_CREATE, 2, 1, 3, 1));
        plan.push_back(row(KIND_CREATE,  0,     5, 1, 1, RES_CREATE, 3, 1, 4, 1));
        plan.push_back(row(KIND_CREATE,  0,     1, 0, 1, RES_CREATE, 4, 1, 5, 1));
        plan.push_back(row(KIND_CREATE,  0,     7, 0, 1, RES_CREATE, 0, 0, 5, 1));
        plan.push_back(row(KIND_SET,    15,     4, 0, 1, RES_DONE,   0, 0, 5, 1));
        plan.push_back(row(KIND_SET,     5,     4, 0, 1, RES_DONE,   0, 0, 5, 1));
        plan.push_back(row(KIND_TICK,    0,     0, 0, 0, RES_DONE,   0, 0, 0, 0));
        plan.push_back(row(KIND_TICK,    0,     0, 0, 0, RES_DONE,   0, 0, 0, 0));
        plan.push_back(row(KIND_SET,     1,     1, 0, 1, RES_DONE,   0, 1, 4, 1));
        plan.push_back(row(KIND_TICK,    0,     0, 0, 0, RES_DONE,   0, 0, 0, 0));
        plan.push_back(row(KIND_SET,     3,     0, 0, 1, RES_DONE,   0, 1, 3, 1));
        plan.push_back(row(KIND_SET,     3,     5, 0, 1, RES_DONE,   0, 0, 3, 1));
        plan.push_back(row(KIND_SET,     1,     0, 1, 1, RES_DONE,   0, 1, 2, 1));
        plan.push_back(row(KIND_SET,     2,     0, 0, 1, RES_DONE,   0, 1, 1, 1));
        plan.push_back(row(KIND_SET,     4,     0, 0, 1, RES_DONE,   0, 1, 0, 0));
        plan.push_back(row(KIND_CREATE,  9, 32767, 1, 1, RES_CREATE, 0, 1, 1, 1));
        plan.push_back(row(KIND_SET,     0,     1, 0, 1, RES_DONE,   0, 1, 1, 1));
        plan.push_back(row(KIND_TICK,    0,     0, 0, 0, RES_DONE,   0, 0, 0, 0));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_cmd(plan[k].cmd, plan[k].typed, plan[k].want);

        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            if (k % 20 == 0)
                idle_on = (k < RANDOM_CMDS - 40) && ($urandom_range(0, 3) != 0);
            send_cmd(random_cmd(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (alarm_reports.size() != 0)
            @(posedge clk);
        repeat (3 * (SLOTS + 2))
            @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== multi_slot_alarm_timer.f =====
+incdir+rtl
rtl/msat_pkg.sv
rtl/msat_cell.sv
rtl/multi_slot_alarm_timer.sv
sim/tb_multi_slot_alarm_timer.sv
